// ===== src/kelf_pkg.sv =====
// ----------------------------------------------------------------------------
// kelf_pkg
// Shared types and constants for the debounced key event queue: operation
// and status codes, register indexes, reset values and controller commands.
// ----------------------------------------------------------------------------
package kelf_pkg;

	// default sizes
	localparam int KELF_NUM_BUTTONS = 8;
	localparam int KELF_QUEUE_DEPTH = 128;

	// field widths
	localparam int OP_W     = 2;
	localparam int BTN_W    = 3;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 32;
	localparam int TIME_W   = 32;
	localparam int LOCK_W   = 16;
	localparam int BUSE_W   = 4;
	localparam int CIDX_W   = 2;
	localparam int CDATA_W  = 16;
	localparam int EVENT_W  = BTN_W + 1 + COUNT_W;

	// register reset values
	localparam logic [LOCK_W-1:0] LOCKOUT_RESET = LOCK_W'(50);
	localparam logic [BUSE_W-1:0] BUTTONS_RESET = BUSE_W'(8);

	// register indexes
	localparam logic [CIDX_W-1:0] REG_LOCKOUT = CIDX_W'(0);
	localparam logic [CIDX_W-1:0] REG_BUTTONS = CIDX_W'(1);

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_EDGE  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} kelf_op_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_LOCKOUT   = 3'd1,
		ST_FULL      = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_BAD_INDEX = 3'd4
	} kelf_status_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic load;
		logic commit;
	} kelf_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic slot_free;
	} kelf_stat_t;

endpackage

// ===== src/kelf_ctrl.sv =====
// ----------------------------------------------------------------------------
// kelf_ctrl
// Sequencer for one transaction at a time: capture the item, load the
// operands, then commit the state update once the result slot is free.
// ----------------------------------------------------------------------------
module kelf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  kelf_pkg::kelf_stat_t stat,
	output kelf_pkg::kelf_cmd_t  cmd
);
	import kelf_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   stall_q;

	// decode commands from the current state
	always_comb begin
		cmd.capture = in_valid && !stall_q && (state_q == S_IDLE);
		cmd.load    = (state_q == S_LOAD);
		cmd.commit  = (state_q == S_EXEC) && stat.slot_free;
	end

	assign in_stall = stall_q;

	// advance state, hold the input stalled while an item is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						state_q <= S_LOAD;
						stall_q <= 1'b1;
					end
				end
				S_LOAD: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cmd.commit) begin
						state_q <= S_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== src/kelf_dpath.sv =====
// ----------------------------------------------------------------------------
// kelf_dpath
// Datapath: time counter, per-button lockout and press counters, event ring
// memory with registered read, configuration registers and result register.
// ----------------------------------------------------------------------------
module kelf_dpath #(
	parameter int NUM_BUTTONS = kelf_pkg::KELF_NUM_BUTTONS,
	parameter int QUEUE_DEPTH = kelf_pkg::KELF_QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kelf_pkg::kelf_cmd_t           cmd,
	output kelf_pkg::kelf_stat_t          stat,
	input  logic [kelf_pkg::OP_W-1:0]     operation,
	input  logic [kelf_pkg::BTN_W-1:0]    button,
	input  logic                          pin_level,
	input  logic                          cfg_we,
	input  logic [kelf_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [kelf_pkg::CDATA_W-1:0]  cfg_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [kelf_pkg::STATUS_W-1:0] status,
	output logic                          event_valid,
	output logic [kelf_pkg::BTN_W-1:0]    event_button,
	output logic                          event_pressed,
	output logic [kelf_pkg::COUNT_W-1:0]  event_count,
	output logic                          queue_not_empty
);
	import kelf_pkg::*;

	// only indexes reachable by the button field need storage
	localparam int BTN_SLOTS = (NUM_BUTTONS < (1 << BTN_W)) ? NUM_BUTTONS : (1 << BTN_W);
	localparam int BTN_IW    = (BTN_SLOTS > 1) ? $clog2(BTN_SLOTS) : 1;
	localparam int PW        = $clog2(QUEUE_DEPTH);
	localparam int LIM_W     = BTN_W + 3;
	localparam logic [LIM_W-1:0] BTN_LIMIT = LIM_W'(NUM_BUTTONS);
	localparam logic [PW-1:0]    PTR_LAST  = PW'(QUEUE_DEPTH - 1);

	// configuration
	logic [LOCK_W-1:0] lockout_q;
	logic [BUSE_W-1:0] buttons_q;

	// block state
	logic [TIME_W-1:0]  time_q;
	logic [TIME_W-1:0]  last_q  [BTN_SLOTS];
	logic [COUNT_W-1:0] press_q [BTN_SLOTS];
	logic [PW-1:0]      rd_ptr_q;
	logic [PW-1:0]      wr_ptr_q;
	logic [EVENT_W-1:0] mem [QUEUE_DEPTH];

	// captured item
	kelf_op_t          op_q;
	logic [BTN_W-1:0]  btn_q;
	logic              lvl_q;

	// operand stage
	logic [TIME_W-1:0]  thr_s1;
	logic [COUNT_W-1:0] cnt_s1;
	logic [COUNT_W-1:0] inc_s1;
	logic [EVENT_W-1:0] rdat_s1;

	// result register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic                ev_valid_q;
	logic [BTN_W-1:0]    ev_btn_q;
	logic                ev_pr_q;
	logic [COUNT_W-1:0]  ev_cnt_q;
	logic                not_empty_q;

	// commit decode
	logic [BTN_IW-1:0]  slot;
	logic               edge_bad;
	logic               clr_bad;
	logic [TIME_W-1:0]  diff;
	logic               locked;
	logic               pressed;
	logic [COUNT_W-1:0] new_cnt;
	logic [PW-1:0]      rd_next;
	logic [PW-1:0]      wr_next;
	logic               full;
	logic               empty;
	logic               do_tick;
	logic               do_accept;
	logic               do_push;
	logic               do_pop;
	logic               do_clear;
	kelf_status_t       st;
	logic [PW-1:0]      rd_n;
	logic [PW-1:0]      wr_n;

	assign stat.slot_free = !out_valid_q || !out_stall;
	assign slot = btn_q[BTN_IW-1:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q <= LOCKOUT_RESET;
			buttons_q <= BUTTONS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOCKOUT: lockout_q <= cfg_data;
				REG_BUTTONS: buttons_q <= cfg_data[BUSE_W-1:0];
				default: ;
			endcase
		end
	end

	// capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= kelf_op_t'(operation);
			btn_q <= button;
			lvl_q <= pin_level;
		end
	end

	// load lockout threshold and press counts; the queue head is read in the ring memory block
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			thr_s1 <= last_q[slot] + TIME_W'(lockout_q);
			cnt_s1 <= press_q[slot];
			inc_s1 <= press_q[slot] + COUNT_W'(1);
		end
	end

	// decide the outcome of the item
	always_comb begin
		edge_bad  = {3'b000, btn_q} >= BTN_LIMIT;
		clr_bad   = edge_bad || ({1'b0, btn_q} >= buttons_q);
		diff      = time_q - thr_s1;
		locked    = diff[TIME_W-1];
		pressed   = ~lvl_q;
		new_cnt   = pressed ? inc_s1 : cnt_s1;
		rd_next   = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
		wr_next   = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
		full      = (wr_next == rd_ptr_q);
		empty     = (rd_ptr_q == wr_ptr_q);
		do_tick   = (op_q == OP_TICK);
		do_accept = (op_q == OP_EDGE) && !edge_bad && !locked;
		do_push   = do_accept && !full;
		do_pop    = (op_q == OP_READ) && !empty;
		do_clear  = (op_q == OP_CLEAR) && !clr_bad;
		case (op_q)
			OP_TICK:  st = ST_OK;
			OP_EDGE:  st = edge_bad ? ST_BAD_INDEX : (locked ? ST_LOCKOUT :
			               (full ? ST_FULL : ST_OK));
			OP_READ:  st = empty ? ST_EMPTY : ST_OK;
			OP_CLEAR: st = clr_bad ? ST_BAD_INDEX : ST_OK;
			default:  st = ST_OK;
		endcase
		rd_n = do_pop ? rd_next : rd_ptr_q;
		wr_n = do_push ? wr_next : wr_ptr_q;
	end

	// update time, per-button state and pointers on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q   <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			for (int i = 0; i < BTN_SLOTS; i++) begin
				last_q[i]  <= '0;
				press_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			if (do_tick) begin
				time_q <= time_q + TIME_W'(1);
			end
			if (do_accept) begin
				last_q[slot]  <= time_q;
				press_q[slot] <= new_cnt;
			end
			if (do_clear) begin
				press_q[slot] <= '0;
			end
			rd_ptr_q <= rd_n;
			wr_ptr_q <= wr_n;
		end
	end

	// event ring memory, registered read of the head entry
	always_ff @(posedge clk) begin
		if (cmd.commit && do_push) begin
			mem[wr_ptr_q] <= {btn_q, pressed, new_cnt};
		end
		if (cmd.load) begin
			rdat_s1 <= mem[rd_ptr_q];
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q    <= st;
			ev_valid_q  <= do_pop;
			ev_btn_q    <= do_pop ? rdat_s1[EVENT_W-1 -: BTN_W] : '0;
			ev_pr_q     <= do_pop ? rdat_s1[COUNT_W] : 1'b0;
			ev_cnt_q    <= do_pop ? rdat_s1[COUNT_W-1:0] : '0;
			not_empty_q <= (rd_n != wr_n);
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign event_valid     = ev_valid_q;
	assign event_button    = ev_btn_q;
	assign event_pressed   = ev_pr_q;
	assign event_count     = ev_cnt_q;
	assign queue_not_empty = not_empty_q;

	// pointers stay inside the ring
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_ptr_q <= PTR_LAST) && (wr_ptr_q <= PTR_LAST))
		else $error("queue pointer outside the ring");

	// a commit never overwrites a result that is still waiting
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || !out_stall))
		else $error("commit while result slot occupied");

	// a commit presents a result on the next cycle
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("commit did not present a result");

	// a returned event always carries an ok status
	a_event_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ev_valid_q) |-> (status_q == ST_OK))
		else $error("event returned with error status");

endmodule

// ===== src/key_event_lockout_fifo.sv =====
// ----------------------------------------------------------------------------
// key_event_lockout_fifo
// Debounced button event queue: ticks, button edges with a per-button
// lockout window, event reads and press count clears, one result each.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries operation, button, pin_level.
//   Output channel (out_valid/out_stall) returns one result per transaction.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   lockout_ticks (index 0) and buttons_in_use (index 1); cfg_ready is
//   always high. Write configuration only while the block is idle.
//   An accepted item passes the capture, operand load and commit steps of
//   the sequencer around the event memory read port, and its result is
//   registered; no new item is taken until the previous one commits.
//   The next item is accepted while a finished result still waits; commit
//   of that item holds until the result register is free.
//   Reset clears time, lockout stamps, press counts, queue pointers and
//   configuration (lockout 50, buttons 8); queue contents are not cleared.
//   When the receiver stalls, the result holds steady and the block keeps
//   the input stalled while the next item waits at its commit step.
// ----------------------------------------------------------------------------
module key_event_lockout_fifo #(
	parameter int NUM_BUTTONS = kelf_pkg::KELF_NUM_BUTTONS,
	parameter int QUEUE_DEPTH = kelf_pkg::KELF_QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [kelf_pkg::OP_W-1:0]     operation,
	input  logic [kelf_pkg::BTN_W-1:0]    button,
	input  logic                          pin_level,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [kelf_pkg::STATUS_W-1:0] status,
	output logic                          event_valid,
	output logic [kelf_pkg::BTN_W-1:0]    event_button,
	output logic                          event_pressed,
	output logic [kelf_pkg::COUNT_W-1:0]  event_count,
	output logic                          queue_not_empty,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kelf_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [kelf_pkg::CDATA_W-1:0]  cfg_data
);
	import kelf_pkg::*;

	kelf_cmd_t  cmd;
	kelf_stat_t stat;
	logic       cfg_we;

	// take configuration writes at any time
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	kelf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	kelf_dpath #(
		.NUM_BUTTONS (NUM_BUTTONS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.operation       (operation),
		.button          (button),
		.pin_level       (pin_level),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.event_valid     (event_valid),
		.event_button    (event_button),
		.event_pressed   (event_pressed),
		.event_count     (event_count),
		.queue_not_empty (queue_not_empty)
	);

endmodule
